/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge while out of reset.
`define WUA_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge while out of reset.
`define WUA_ASSERT_NEVER(label, cond, msg) \
    `WUA_ASSERT_CLK(label, !(cond), msg)

`endif

/* hdl/wua_pkg.sv */
package wua_pkg;

    localparam int LIMB_W  = 32;
    localparam int WORD_W  = 3 * LIMB_W;
    localparam int SHIFT_W = 8;
    localparam int SUM_W   = 8;

    typedef enum logic [2:0] {
        ACT_LESS      = 3'd0,
        ACT_EQUAL     = 3'd1,
        ACT_ADD_SAT   = 3'd2,
        ACT_ADD_WRAP  = 3'd3,
        ACT_SUB_FLOOR = 3'd4,
        ACT_SOFT_THR  = 3'd5,
        ACT_SHIFT_R   = 3'd6,
        ACT_CHECKSUM  = 3'd7
    } action_t;

    typedef logic [WORD_W-1:0] word_t;

endpackage

/* hdl/wua_alu.sv */
module wua_alu
(
    input  wua_pkg::action_t             action,
    input  wua_pkg::word_t               a,
    input  wua_pkg::word_t               b,
    input  logic [wua_pkg::SHIFT_W-1:0]  shift_amount,
    output wua_pkg::word_t               result,
    output logic                         compare_flag
);
    import wua_pkg::*;

    logic              sub_mode;
    logic [WORD_W:0]   sum;
    logic              carry;
    logic              a_eq_b;
    word_t             shifted;
    logic [SUM_W-1:0]  check_byte;

    // One shared adder: a + b for adds, a + ~b + 1 for compare and subtract.
    assign sub_mode = (action != ACT_ADD_SAT) && (action != ACT_ADD_WRAP);
    assign sum      = {1'b0, a} + {1'b0, (sub_mode ? ~b : b)} + (WORD_W+1)'(sub_mode);
    // Add: carry means overflow. Subtract: carry means no borrow, a >= b.
    assign carry    = sum[WORD_W];
    assign a_eq_b   = (a == b);

    // Distances of 32 and above flush the word.
    assign shifted = (shift_amount[SHIFT_W-1:5] != '0) ? '0 : (a >> shift_amount[4:0]);

    // Only the low byte survives, so weigh the low byte of each limb.
    assign check_byte = {a[2*LIMB_W +: SUM_W-1], 1'b0}
                      + a[LIMB_W +: SUM_W]
                      + {a[LIMB_W +: SUM_W-1], 1'b0}
                      + {a[0 +: SUM_W-2], 2'b00};

    always_comb
    begin
        result       = '0;
        compare_flag = 1'b0;
        case (action)
            ACT_LESS:      compare_flag = ~carry;
            ACT_EQUAL:     compare_flag = a_eq_b;
            ACT_ADD_SAT:   result = carry ? '1 : sum[WORD_W-1:0];
            ACT_ADD_WRAP:  result = sum[WORD_W-1:0];
            ACT_SUB_FLOOR: result = carry ? sum[WORD_W-1:0] : '0;
            ACT_SOFT_THR:  result = (carry && !a_eq_b) ? sum[WORD_W-1:0] : '0;
            ACT_SHIFT_R:   result = shifted;
            ACT_CHECKSUM:  result = WORD_W'(check_byte);
            default:       result = '0;
        endcase
    end

endmodule

/* hdl/wide_unsigned_saturating_alu.sv */
// 96-bit unsigned ALU (compare, saturating/wrapping add, clamped subtract,
// soft threshold, logical right shift, checksum byte) on three 32-bit limbs,
// high limb first. Two register stages: an accepted beat is captured in the
// input register, passes one 97-bit shared adder and its selection logic,
// and lands in the result register, which offers it on the outputs. One beat
// is accepted every cycle while in_ready is high; in_ready drops only when
// both stages hold beats and out_ready is low. No state survives between
// beats and reset only clears the valid flags.
module wide_unsigned_saturating_alu
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   action,
    input  logic [wua_pkg::LIMB_W-1:0]   a_high,
    input  logic [wua_pkg::LIMB_W-1:0]   a_middle,
    input  logic [wua_pkg::LIMB_W-1:0]   a_low,
    input  logic [wua_pkg::LIMB_W-1:0]   b_high,
    input  logic [wua_pkg::LIMB_W-1:0]   b_middle,
    input  logic [wua_pkg::LIMB_W-1:0]   b_low,
    input  logic [wua_pkg::SHIFT_W-1:0]  shift_amount,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wua_pkg::LIMB_W-1:0]   result_high,
    output logic [wua_pkg::LIMB_W-1:0]   result_middle,
    output logic [wua_pkg::LIMB_W-1:0]   result_low,
    output logic                         compare_flag
);
    import wua_pkg::*;

    logic                in_valid_reg;
    action_t             action_reg;
    word_t               a_reg;
    word_t               b_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    logic                out_valid_reg;
    word_t               result_reg;
    logic                flag_reg;

    word_t               result_next;
    logic                flag_next;
    logic                out_load;
    logic                in_load;

    // Result stage takes a new beat when empty or being drained.
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            action_reg <= action_t'(action);
            a_reg      <= {a_high, a_middle, a_low};
            b_reg      <= {b_high, b_middle, b_low};
            shift_reg  <= shift_amount;
        end
        if (out_load && in_valid_reg)
        begin
            result_reg <= result_next;
            flag_reg   <= flag_next;
        end
    end

    wua_alu u_alu
    (
        .action       (action_reg),
        .a            (a_reg),
        .b            (b_reg),
        .shift_amount (shift_reg),
        .result       (result_next),
        .compare_flag (flag_next)
    );

    assign out_valid     = out_valid_reg;
    assign result_high   = result_reg[2*LIMB_W +: LIMB_W];
    assign result_middle = result_reg[LIMB_W +: LIMB_W];
    assign result_low    = result_reg[0 +: LIMB_W];
    assign compare_flag  = flag_reg;

endmodule

/* hdl/wua_checker.sv */
`include "assert_macros.svh"

module wua_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [2:0]   action,
    input  logic [31:0]  a_high,
    input  logic [31:0]  a_middle,
    input  logic [31:0]  a_low,
    input  logic [31:0]  b_high,
    input  logic [31:0]  b_middle,
    input  logic [31:0]  b_low,
    input  logic [7:0]   shift_amount,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [31:0]  result_high,
    input  logic [31:0]  result_middle,
    input  logic [31:0]  result_low,
    input  logic         compare_flag
);

    // Hold a stalled result beat.
    `WUA_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_middle) && $stable(result_low) && $stable(compare_flag), "stalled result beat changed")

    // A set flag only comes from a compare, whose limbs are all zero.
    `WUA_ASSERT_NEVER(a_flag_zero, out_valid && compare_flag && (result_high != '0 || result_middle != '0 || result_low != '0), "compare beat carries a nonzero result")

    // A draining output never throttles the input side.
    `WUA_ASSERT_CLK(a_ready_flow, out_ready |-> in_ready, "in_ready low while out_ready high")

    // A result beat rising from idle comes from an accepted input beat that passed the input register.
    `WUA_ASSERT_CLK(a_no_phantom, out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2), "result beat without an accepted input")

endmodule

bind wide_unsigned_saturating_alu wua_checker u_wua_checker (.*);
